FILE: rtl/core/scs_pkg.sv
`timescale 1ns / 1ps

package scs_pkg;

   // Window depth default, handed to the top level parameter
   localparam int DEFAULT_WINDOW_BYTES = 4;

   // Configuration port geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes (paddr[4:2])
   localparam logic [2:0] REG_LINE_OPEN_TEXT  = 3'd0;
   localparam logic [2:0] REG_LINE_OPEN_LEN   = 3'd1;
   localparam logic [2:0] REG_BLOCK_OPEN_TEXT = 3'd2;
   localparam logic [2:0] REG_BLOCK_OPEN_LEN  = 3'd3;
   localparam logic [2:0] REG_BLOCK_CLOSE_TEXT = 3'd4;
   localparam logic [2:0] REG_BLOCK_CLOSE_LEN = 3'd5;

   // Register reset values: "//", 2, "/*", 2, "*/", 2
   localparam logic [15:0] RST_LINE_OPEN_TEXT   = 16'h2F2F;
   localparam logic [1:0]  RST_LINE_OPEN_LEN    = 2'd2;
   localparam logic [31:0] RST_BLOCK_OPEN_TEXT  = 32'h0000_2A2F;
   localparam logic [2:0]  RST_BLOCK_OPEN_LEN   = 3'd2;
   localparam logic [31:0] RST_BLOCK_CLOSE_TEXT = 32'h0000_2F2A;
   localparam logic [2:0]  RST_BLOCK_CLOSE_LEN  = 3'd2;

   // Longest delimiters the registers can describe
   localparam logic [1:0] MAX_LINE_LEN  = 2'd2;
   localparam logic [2:0] MAX_BLOCK_LEN = 3'd4;

   // Character codes
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_APOS      = 8'h27;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   // Scanner state carried from one judged byte to the next
   typedef struct packed {
      logic [1:0] skip_count;
      logic       in_block_comment;
      logic       in_line_comment;
      logic       in_quote;
      logic       in_apostrophe;
      logic       escape_pending;
      logic       found_flag;
   } scan_state_type;

   localparam scan_state_type SCAN_STATE_RESET = '{default: '0};

endpackage

FILE: rtl/core/scs_if.sv
`timescale 1ns / 1ps

// Source text channel
interface scs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

// Stripped text channel
interface scs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       end_marker;
   logic       comments_seen;

   modport source (output valid, output out_byte, output byte_valid, output end_marker,
                   output comments_seen, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input end_marker,
                 input comments_seen, output ready);
endinterface

FILE: rtl/core/source_comment_stripper.sv
`timescale 1ns / 1ps
// Path: a kept byte passes the input register, then the result register, after the
//   transaction that completes its WINDOW_BYTES-deep lookahead window.
// Throughput: one source byte per cycle unless the result side stalls or a flush runs; the
//   final byte of a text starts a flush of the window, one judged byte per cycle, then the end marker.
// Reset: synchronous, active high; clears the stream state and loads the default
//   delimiters ("//", "/*", "*/").
module source_comment_stripper #(
   parameter int WINDOW_BYTES = scs_pkg::DEFAULT_WINDOW_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   scs_req_if.sink                       req,
   scs_rsp_if.source                     rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [scs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [scs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [scs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready
);
   import scs_pkg::*;

   localparam int FILL_W    = $clog2(WINDOW_BYTES + 1);
   localparam int CMP_BYTES = (WINDOW_BYTES < 4) ? WINDOW_BYTES : 4;

   typedef logic [WINDOW_BYTES-1:0][7:0] win_type;

   // Delimiter compare at the head of the window
   function automatic logic win_match(win_type w, logic [FILL_W-1:0] f,
                                      logic [31:0] text, logic [2:0] len);
      logic m;
      m = (int'(len) <= WINDOW_BYTES);
      for (int k = 0; k < CMP_BYTES; k++) begin
         if (3'(k) < len) begin
            if (FILL_W'(k) >= f || w[k] != text[8*k +: 8]) begin
               m = 1'b0;
            end
         end
      end
      return m;
   endfunction

   // Configuration registers
   logic [15:0] line_open_text_ff;
   logic [1:0]  line_open_len_ff;
   logic [31:0] block_open_text_ff;
   logic [2:0]  block_open_len_ff;
   logic [31:0] block_close_text_ff;
   logic [2:0]  block_close_len_ff;
   logic [2:0]  csr_index;
   logic        csr_write;

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Stream state
   win_type             win_ff, win_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   scan_state_type      state_ff, state_in;
   logic                flush_ff, flush_in;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff;
   logic       byte_valid_ff;
   logic       end_marker_ff;
   logic       comments_seen_ff;

   // Datapath
   logic              out_free;
   logic              step;
   logic              marker;
   logic              do_judge;
   win_type           view_win;
   win_type           shift_win;
   logic [FILL_W-1:0] view_fill;
   scan_state_type    judged;
   logic              emit;
   logic              taken;
   logic [7:0]        head;
   logic [1:0]        llen;
   logic [2:0]        olen;
   logic [2:0]        clen;

   // APB register access
   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_open_text_ff   <= RST_LINE_OPEN_TEXT;
         line_open_len_ff    <= RST_LINE_OPEN_LEN;
         block_open_text_ff  <= RST_BLOCK_OPEN_TEXT;
         block_open_len_ff   <= RST_BLOCK_OPEN_LEN;
         block_close_text_ff <= RST_BLOCK_CLOSE_TEXT;
         block_close_len_ff  <= RST_BLOCK_CLOSE_LEN;
      end else if (csr_write) begin
         case (csr_index)
            REG_LINE_OPEN_TEXT:   line_open_text_ff   <= pwdata[15:0];
            REG_LINE_OPEN_LEN:    line_open_len_ff    <= pwdata[1:0];
            REG_BLOCK_OPEN_TEXT:  block_open_text_ff  <= pwdata;
            REG_BLOCK_OPEN_LEN:   block_open_len_ff   <= pwdata[2:0];
            REG_BLOCK_CLOSE_TEXT: block_close_text_ff <= pwdata;
            REG_BLOCK_CLOSE_LEN:  block_close_len_ff  <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_LINE_OPEN_TEXT:   prdata = {16'd0, line_open_text_ff};
         REG_LINE_OPEN_LEN:    prdata = {30'd0, line_open_len_ff};
         REG_BLOCK_OPEN_TEXT:  prdata = block_open_text_ff;
         REG_BLOCK_OPEN_LEN:   prdata = {29'd0, block_open_len_ff};
         REG_BLOCK_CLOSE_TEXT: prdata = block_close_text_ff;
         REG_BLOCK_CLOSE_LEN:  prdata = {29'd0, block_close_len_ff};
         default:              prdata = '0;
      endcase
   end

   // Handshake: the result register frees a slot, the input register refills behind it
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign step      = out_free && (flush_ff || in_valid_ff);
   assign req.ready = !in_valid_ff || (out_free && !flush_ff);

   // Window as seen this cycle: stored bytes plus, outside a flush, the registered new byte
   always_comb begin
      for (int k = 0; k < WINDOW_BYTES; k++) begin
         view_win[k] = (flush_ff || FILL_W'(k) != fill_ff) ? win_ff[k] : in_byte_ff;
      end
      for (int k = 0; k < WINDOW_BYTES; k++) begin
         shift_win[k] = (k < WINDOW_BYTES - 1) ? view_win[(k + 1) % WINDOW_BYTES] : 8'd0;
      end
      view_fill = flush_ff ? fill_ff : fill_ff + FILL_W'(1);
      marker    = flush_ff && (fill_ff == '0);
      do_judge  = flush_ff ? (fill_ff != '0)
                           : (in_valid_ff && !in_last_ff
                              && view_fill == FILL_W'(WINDOW_BYTES));
   end

   // Judge the head byte
   always_comb begin
      head   = view_win[0];
      llen   = (line_open_len_ff > MAX_LINE_LEN) ? MAX_LINE_LEN : line_open_len_ff;
      olen   = (block_open_len_ff > MAX_BLOCK_LEN) ? MAX_BLOCK_LEN : block_open_len_ff;
      clen   = (block_close_len_ff > MAX_BLOCK_LEN) ? MAX_BLOCK_LEN : block_close_len_ff;
      judged = state_ff;
      emit   = 1'b0;
      taken  = 1'b0;
      if (state_ff.skip_count != 2'd0) begin
         // swallow the rest of a matched delimiter
         judged.skip_count = state_ff.skip_count - 2'd1;
      end else if (state_ff.in_line_comment) begin
         if (head == CHAR_NEWLINE) begin
            emit                   = 1'b1;
            judged.in_line_comment = 1'b0;
         end
      end else begin
         if (!state_ff.in_block_comment && !state_ff.in_quote && !state_ff.in_apostrophe) begin
            if (olen != 3'd0
                && win_match(view_win, view_fill, block_open_text_ff, olen)) begin
               judged.in_block_comment = 1'b1;
               judged.found_flag       = 1'b1;
               judged.skip_count       = 2'(olen - 3'd1);
               taken                   = 1'b1;
            end else if (llen != 2'd0
                         && win_match(view_win, view_fill, {16'd0, line_open_text_ff},
                                      {1'b0, llen})) begin
               judged.found_flag = 1'b1;
               if (head == CHAR_NEWLINE) begin
                  emit = 1'b1;
               end else begin
                  judged.in_line_comment = 1'b1;
               end
               taken = 1'b1;
            end
         end
         if (!taken) begin
            // literal tracking, escapes shield the next byte
            if (!state_ff.in_block_comment && !state_ff.escape_pending) begin
               if (head == CHAR_QUOTE && !state_ff.in_apostrophe) begin
                  judged.in_quote = !state_ff.in_quote;
               end else if (head == CHAR_APOS && !state_ff.in_quote) begin
                  judged.in_apostrophe = !state_ff.in_apostrophe;
               end
            end
            judged.escape_pending = (judged.in_quote || judged.in_apostrophe)
                                    && head == CHAR_BACKSLASH && !state_ff.escape_pending;
            if (!state_ff.in_block_comment) begin
               emit = 1'b1;
            end else if (clen != 3'd0
                         && win_match(view_win, view_fill, block_close_text_ff, clen)) begin
               judged.in_block_comment = 1'b0;
               judged.skip_count       = 2'(clen - 3'd1);
            end
         end
      end
   end

   // Next stream state
   always_comb begin
      win_in   = win_ff;
      fill_in  = fill_ff;
      state_in = state_ff;
      flush_in = flush_ff;
      if (step) begin
         if (marker) begin
            win_in   = '0;
            fill_in  = '0;
            state_in = SCAN_STATE_RESET;
            flush_in = 1'b0;
         end else begin
            win_in   = do_judge ? shift_win : view_win;
            fill_in  = view_fill - FILL_W'(do_judge);
            state_in = do_judge ? judged : state_ff;
            if (!flush_ff && in_last_ff) begin
               flush_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         fill_ff  <= '0;
         state_ff <= SCAN_STATE_RESET;
         flush_ff <= 1'b0;
      end else begin
         win_ff   <= win_in;
         fill_ff  <= fill_in;
         state_ff <= state_in;
         flush_ff <= flush_in;
      end
   end

   // Input register
   assign in_valid_in = req.ready ? req.valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.in_byte;
         in_last_ff <= req.end_of_text;
      end
   end

   // Result register
   assign rsp_valid_in = out_free ? (step && (marker || (do_judge && emit))) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_byte_ff      <= marker ? 8'd0 : view_win[0];
         byte_valid_ff    <= !marker;
         end_marker_ff    <= marker;
         comments_seen_ff <= marker && state_ff.found_flag;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_byte      = out_byte_ff;
   assign rsp.byte_valid    = byte_valid_ff;
   assign rsp.end_marker    = end_marker_ff;
   assign rsp.comments_seen = comments_seen_ff;

endmodule

FILE: test/scs_tb_pkg.sv
`timescale 1ns / 1ps

package scs_tb_pkg;
   import scs_pkg::*;

   // Register slot that the block does not decode; writes to it must be ignored
   localparam logic [2:0] REG_SPARE = 3'd6;

   localparam int TB_WINDOW_BYTES = DEFAULT_WINDOW_BYTES;

   // One result transaction, in port order
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_marker;
      logic       comments_seen;
   } strip_result_type;

   typedef logic [7:0] text_q_type[$];

   // Mirrors the stripper: delimiter registers, scan state and the queue of
   // result transactions still owed by the block.
   class stripped_text_board;
      logic [15:0] line_text;
      logic [1:0]  line_len;
      logic [31:0] open_text;
      logic [2:0]  open_len;
      logic [31:0] close_text;
      logic [2:0]  close_len;

      logic [7:0] win [TB_WINDOW_BYTES];
      int         fill;
      int         skip;
      bit         in_block, in_line, in_quote, in_apos, escape, found;

      strip_result_type kept_expected[$];
      int               failures;

      function new();
         line_text  = RST_LINE_OPEN_TEXT;
         line_len   = RST_LINE_OPEN_LEN;
         open_text  = RST_BLOCK_OPEN_TEXT;
         open_len   = RST_BLOCK_OPEN_LEN;
         close_text = RST_BLOCK_CLOSE_TEXT;
         close_len  = RST_BLOCK_CLOSE_LEN;
         failures   = 0;
         clear_stream();
      endfunction

      function void clear_stream();
         foreach (win[k]) win[k] = '0;
         fill     = 0;
         skip     = 0;
         in_block = 0;
         in_line  = 0;
         in_quote = 0;
         in_apos  = 0;
         escape   = 0;
         found    = 0;
      endfunction

      function void set_reg(input logic [2:0] idx, input logic [31:0] val);
         case (idx)
            REG_LINE_OPEN_TEXT:   line_text  = val[15:0];
            REG_LINE_OPEN_LEN:    line_len   = val[1:0];
            REG_BLOCK_OPEN_TEXT:  open_text  = val;
            REG_BLOCK_OPEN_LEN:   open_len   = val[2:0];
            REG_BLOCK_CLOSE_TEXT: close_text = val;
            REG_BLOCK_CLOSE_LEN:  close_len  = val[2:0];
            default: ;
         endcase
      endfunction

      // Over-long lengths saturate at the longest delimiter the window handles
      function int line_eff();
         return (line_len > MAX_LINE_LEN) ? int'(MAX_LINE_LEN) : int'(line_len);
      endfunction

      function int open_eff();
         return (open_len > MAX_BLOCK_LEN) ? int'(MAX_BLOCK_LEN) : int'(open_len);
      endfunction

      function int close_eff();
         return (close_len > MAX_BLOCK_LEN) ? int'(MAX_BLOCK_LEN) : int'(close_len);
      endfunction

      // Delimiter compare at the window head; bytes past the fill never match
      function bit window_hits(input logic [31:0] text, input int len);
         if (len > TB_WINDOW_BYTES) return 1'b0;
         for (int k = 0; k < len; k++) begin
            if (k >= fill) return 1'b0;
            if (win[k] != text[8*k +: 8]) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void keep_byte(input logic [7:0] b);
         strip_result_type r;
         r.out_byte      = b;
         r.byte_valid    = 1'b1;
         r.end_marker    = 1'b0;
         r.comments_seen = 1'b0;
         kept_expected.push_back(r);
      endfunction

      // Decide the fate of the head byte, then shift the window by one
      function void judge_head_byte();
         logic [7:0] b;
         bit         taken;
         b = win[0];
         if (skip > 0) begin
            skip--;
         end else if (in_line) begin
            if (b == CHAR_NEWLINE) begin
               keep_byte(b);
               in_line = 0;
            end
         end else begin
            taken = 0;
            if (!in_block && !in_quote && !in_apos) begin
               if (open_eff() > 0 && window_hits(open_text, open_eff())) begin
                  in_block = 1;
                  found    = 1;
                  skip     = open_eff() - 1;
                  taken    = 1;
               end else if (line_eff() > 0 && window_hits({16'h0, line_text}, line_eff())) begin
                  found = 1;
                  // opener that starts on a newline keeps it and ends at once
                  if (b == CHAR_NEWLINE) keep_byte(b);
                  else in_line = 1;
                  taken = 1;
               end
            end
            if (!taken) begin
               if (!in_block && !escape) begin
                  if (b == CHAR_QUOTE && !in_apos) in_quote = !in_quote;
                  else if (b == CHAR_APOS && !in_quote) in_apos = !in_apos;
               end
               escape = (in_quote || in_apos) && b == CHAR_BACKSLASH && !escape;
               if (!in_block) begin
                  keep_byte(b);
               end else if (close_eff() > 0 && window_hits(close_text, close_eff())) begin
                  in_block = 0;
                  skip     = close_eff() - 1;
               end
            end
         end
         for (int k = 1; k < TB_WINDOW_BYTES; k++) win[k-1] = win[k];
         win[TB_WINDOW_BYTES-1] = '0;
         if (fill > 0) fill--;
      endfunction

      // Accepted source transaction: push every result it is owed
      function void take_source(input logic [7:0] b, input logic eot);
         strip_result_type r;
         if (fill >= TB_WINDOW_BYTES) judge_head_byte();
         win[fill] = b;
         fill++;
         if (fill >= TB_WINDOW_BYTES && !eot) judge_head_byte();
         if (eot) begin
            while (fill > 0) judge_head_byte();
            r.out_byte      = '0;
            r.byte_valid    = 1'b0;
            r.end_marker    = 1'b1;
            r.comments_seen = found;
            kept_expected.push_back(r);
            clear_stream();
         end
      endfunction

      function int pending();
         return kept_expected.size();
      endfunction

      function void note_failure(input string what, input strip_result_type want,
                                 input strip_result_type got);
         failures++;
         if (failures <= 10)
            $display("%0t %s: expected %02h v%0b e%0b c%0b, actual %02h v%0b e%0b c%0b",
                     $realtime, what, want.out_byte, want.byte_valid, want.end_marker,
                     want.comments_seen, got.out_byte, got.byte_valid, got.end_marker,
                     got.comments_seen);
      endfunction

      // Accepted result transaction against the oldest expectation
      function void check_kept(input strip_result_type got);
         strip_result_type want;
         if (kept_expected.size() == 0) begin
            note_failure("unexpected transaction", '0, got);
            return;
         end
         want = kept_expected.pop_front();
         if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
             got.end_marker !== want.end_marker || got.comments_seen !== want.comments_seen)
            note_failure("mismatch", want, got);
      endfunction

      function void close_out();
         while (kept_expected.size() > 0)
            note_failure("missing transaction", kept_expected.pop_front(), '0);
      endfunction
   endclass

endpackage

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import scs_pkg::*;
   import scs_tb_pkg::*;

   localparam int LONG_HOLD     = 150;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASE_ITEMS   = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bit long_hold_req = 1'b0;

   stripped_text_board board;

   scs_req_if req_if ();
   scs_rsp_if rsp_if ();

   source_comment_stripper i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // APB write: setup cycle, then access cycle until pready
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.set_reg(idx, val);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // One source transaction after an idle gap
   task automatic send_byte(input logic [7:0] b, input logic eot, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.in_byte     <= b;
      req_if.end_of_text <= eot;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.take_source(b, eot);
   endtask

   task automatic send_text(input text_q_type txt, input bit burst);
      for (int i = 0; i < txt.size(); i++)
         send_byte(txt[i], i == txt.size() - 1, burst ? 0 : $urandom_range(0, 19));
   endtask

   // Drop valid, wait for every owed result, then let the block settle
   task automatic wait_idle();
      int waited;
      @(negedge clock);
      req_if.valid <= 1'b0;
      waited = 0;
      while (board.pending() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Text built mostly from the current delimiters, quotes, escapes and newlines
   function automatic text_q_type random_text(input int len);
      text_q_type  t;
      int          pick, dlen;
      logic [31:0] dtext;
      bit          noise;
      noise = ($urandom_range(0, 5) == 0);
      while (t.size() < len) begin
         pick  = noise ? 11 : $urandom_range(0, 15);
         dlen  = 0;
         dtext = '0;
         case (pick)
            0, 1, 2: begin
               dtext = {16'h0, board.line_text};
               dlen  = board.line_eff();
            end
            3, 4: begin
               dtext = board.open_text;
               dlen  = board.open_eff();
            end
            5, 6: begin
               dtext = board.close_text;
               dlen  = board.close_eff();
            end
            7:  t.push_back(CHAR_QUOTE);
            8:  t.push_back(CHAR_APOS);
            9:  t.push_back(CHAR_BACKSLASH);
            10: t.push_back(CHAR_NEWLINE);
            11: t.push_back(8'($urandom));
            default: t.push_back(8'($urandom_range(97, 122)));
         endcase
         if (pick <= 6) begin
            if (dlen == 0) dlen = 2;
            // a cut delimiter now and then
            if ($urandom_range(0, 3) == 0) dlen = $urandom_range(1, dlen);
            for (int k = 0; k < dlen; k++) t.push_back(dtext[8*k +: 8]);
         end
      end
      return t;
   endfunction

   task automatic run_phase(input logic [15:0] lt, input logic [1:0] ll,
                            input logic [31:0] ot, input logic [2:0] ol,
                            input logic [31:0] ct, input logic [2:0] cl, input bit burst);
      int sent;
      write_reg(REG_LINE_OPEN_TEXT, {16'h0, lt});
      write_reg(REG_LINE_OPEN_LEN, {30'h0, ll});
      write_reg(REG_BLOCK_OPEN_TEXT, ot);
      write_reg(REG_BLOCK_OPEN_LEN, {29'h0, ol});
      write_reg(REG_BLOCK_CLOSE_TEXT, ct);
      write_reg(REG_BLOCK_CLOSE_LEN, {29'h0, cl});
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         text_q_type txt;
         txt = random_text($urandom_range(1, 14));
         send_text(txt, burst);
         sent += txt.size();
      end
      wait_idle();
   endtask

   // Result side: random stalls, calm stretches, and one long hold-off
   initial begin
      strip_result_type got;
      int               gap, served;
      bit               calm;
      rsp_if.ready = 1'b0;
      served = 0;
      calm   = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (served % 25 == 0) calm = ($urandom_range(0, 2) == 0);
         if (long_hold_req) begin
            gap           = LONG_HOLD;
            long_hold_req = 1'b0;
         end else begin
            gap = calm ? 0 : $urandom_range(0, 19);
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         got.out_byte      = rsp_if.out_byte;
         got.byte_valid    = rsp_if.byte_valid;
         got.end_marker    = rsp_if.end_marker;
         got.comments_seen = rsp_if.comments_seen;
         board.check_kept(got);
         served++;
      end
   end

   // Stimulus
   initial begin
      text_q_type txt;
      board = new();
      req_if.valid       = 1'b0;
      req_if.in_byte     = '0;
      req_if.end_of_text = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default delimiters: byte extremes, escaped quote shielding a line opener,
      // block comment, apostrophe shielding a block opener, line comment to newline
      txt = '{8'h00, 8'hFF, CHAR_QUOTE, CHAR_BACKSLASH, CHAR_QUOTE, "/", "/", CHAR_QUOTE,
              "/", "*", "c", "*", "/", CHAR_APOS, "/", "*", CHAR_APOS, "/", "/", "z",
              CHAR_NEWLINE, "q"};
      send_text(txt, 1'b0);
      // opener cut off by the end of the text
      txt = '{"/"};
      send_text(txt, 1'b0);
      // block comment still open at the end of the text
      txt = '{"/", "*", "x"};
      send_text(txt, 1'b0);
      wait_idle();

      // undecoded register slot
      write_reg(REG_SPARE, $urandom);
      // four-byte opener, three-byte closer, line comments off
      run_phase(16'h2F2F, 2'd0, 32'h2D2D_213C, 3'd4, 32'h003E_2D2D, 3'd3, 1'b0);
      // single-byte line opener, block comments off; receiver holds off meanwhile
      long_hold_req = 1'b1;
      run_phase(16'h0023, 2'd1, 32'h0000_2A2F, 3'd0, 32'h0000_2F2A, 3'd0, 1'b1);
      // line opener starting with a newline, one-byte block delimiters
      run_phase(16'h230A, 2'd2, 32'h0000_007B, 3'd1, 32'h0000_007D, 3'd1, 1'b0);
      // lengths beyond the longest delimiter
      run_phase(16'h2D2D, 2'd3, 32'h2A28_2A28, 3'd5, 32'h292A_292A, 3'd7, 1'b1);
      // block comment with no closer
      run_phase(16'h2F2F, 2'd0, 32'h0000_2A2F, 3'd2, 32'h0000_2F2A, 3'd0, 1'b0);
      // all-ones and zero delimiter bytes
      run_phase(16'hFFFF, 2'd2, 32'h0000_0000, 3'd3, 32'hFFFF_FFFF, 3'd4, 1'b0);
      run_phase(16'h0000, 2'd2, 32'hFFFF_FFFF, 3'd4, 32'h0000_0000, 3'd1, 1'b1);
      // random delimiter settings
      repeat (2)
         run_phase(16'($urandom), 2'($urandom), $urandom, 3'($urandom), $urandom,
                   3'($urandom_range(1, 7)), 1'b0);
      // back to the reset delimiters
      run_phase(RST_LINE_OPEN_TEXT, RST_LINE_OPEN_LEN, RST_BLOCK_OPEN_TEXT,
                RST_BLOCK_OPEN_LEN, RST_BLOCK_CLOSE_TEXT, RST_BLOCK_CLOSE_LEN, 1'b0);

      board.close_out();
      if (board.failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: source_comment_stripper.f
rtl/core/scs_pkg.sv
rtl/core/scs_if.sv
rtl/core/source_comment_stripper.sv
test/scs_tb_pkg.sv
test/tb_top.sv
